// ===== rtl/core/tsp_pkg.sv =====
package tsp_pkg;

    // Field widths of the report and result items.
    localparam int TASK_INDEX_W = 6;
    localparam int EPOCH_IO_W   = 48;
    localparam int TIER_W       = 1;
    localparam int CHANGE_W     = 2;
    localparam int FAST_W       = 7;
    localparam int IDLE_W       = 5;
    localparam int SUM_W        = 64;
    localparam int EPOCH_NUM_W  = 32;

    // Packed stream widths, rounded up to whole bytes.
    localparam int S_DATA_BITS = TASK_INDEX_W + EPOCH_IO_W;
    localparam int S_DATA_W    = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS = TASK_INDEX_W + TIER_W + CHANGE_W + FAST_W + IDLE_W
                                 + SUM_W + SUM_W + EPOCH_NUM_W;
    localparam int M_DATA_W    = ((M_DATA_BITS + 7) / 8) * 8;

    // Every slot that a task index can name.
    localparam int INDEX_SPAN = 1 << TASK_INDEX_W;

    // Configuration port.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_SPLIT_POINT = 2'd0;
    localparam logic [1:0] REG_IDLE_LIMIT  = 2'd1;
    localparam logic [1:0] REG_DYNAMIC     = 2'd2;

    localparam logic [FAST_W-1:0] SPLIT_RESET   = 7'd0;
    localparam logic [IDLE_W-1:0] LIMIT_RESET   = 5'd16;
    localparam logic              DYNAMIC_RESET = 1'b1;

    // Idle counter saturates here.
    localparam logic [IDLE_W-1:0] IDLE_MAX = 5'd31;

    // Placement change codes.
    localparam logic [CHANGE_W-1:0] CHG_NONE    = 2'd0;
    localparam logic [CHANGE_W-1:0] CHG_PROMOTE = 2'd1;
    localparam logic [CHANGE_W-1:0] CHG_DEMOTE  = 2'd2;

    typedef struct packed {
        logic [FAST_W-1:0] split_point;
        logic [IDLE_W-1:0] idle_limit;
        logic              dynamic_en;
    } t_cfg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RMW,
        ST_FOLD
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
        logic commit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

// ===== rtl/core/tiered_storage_placement_epoch.sv =====
// End-of-epoch placement policy for a fast and a slow storage tier.
// Input stream: one beat per task report; tdata carries the task index and
// the epoch I/O amount, tlast marks the final report of the epoch.
// Output stream: one result beat per report with the task's tier, the change
// made, the fast-tier count, the idle counter, the epoch and aggregate I/O
// totals and the epoch number; tlast echoes the report's tlast.
// Configuration registers sit on the APB port: split point at 0x0, idle
// epoch limit at 0x4, dynamic enable at 0x8. Write them only while idle.
// A report is captured and its entry read at the edge that accepts it, the
// entry is updated in the read-modify-write step and the result is then
// folded into the output register in the fold step. The block takes one
// report at a time, since the read-modify-write of the task entry memory and
// the aggregate fold finish before the next report is accepted.
// A stalled receiver holds the result in the output register; the block
// then waits in its fold step and stops taking reports until the beat drains.
// Reset clears all task entries to slow and not idle through per-slot valid
// bits, zeroes the counters and sums, and loads the register defaults; ready
// is low during reset and rises as soon as reset is released.
module tiered_storage_placement_epoch #(
    parameter int TASK_SLOTS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Report beats.
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // tdata: task_index [5:0], epoch_io [53:6], zero fill [55:54]
    input  logic [tsp_pkg::S_DATA_W-1:0]    i_s_tdata,
    input  logic                            i_s_tlast,
    // Result beats.
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // tdata: task_id [5:0], tier [6], change [8:7], fast_users [15:9],
    // idle_epochs [20:16], epoch_sum [84:21], total_io [148:85],
    // epoch_number [180:149], zero fill [183:181]
    output logic [tsp_pkg::M_DATA_W-1:0]    o_m_tdata,
    output logic                            o_m_tlast,
    // Configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tsp_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [tsp_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [tsp_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    tsp_pkg::t_cfg    cfg;
    tsp_pkg::t_dp_cmd cmd;
    tsp_pkg::t_dp_sts sts;

    tsp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tsp_dp #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// ===== rtl/core/tsp_ram.sv =====
module tsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/tsp_cfg.sv =====
module tsp_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tsp_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [tsp_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [tsp_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output tsp_pkg::t_cfg                   o_cfg
);

    tsp_pkg::t_cfg r_cfg;
    logic          wr_en;
    logic [1:0]    reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];

    // Register writes; addresses past the last register are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.split_point <= tsp_pkg::SPLIT_RESET;
            r_cfg.idle_limit  <= tsp_pkg::LIMIT_RESET;
            r_cfg.dynamic_en  <= tsp_pkg::DYNAMIC_RESET;
        end else if (wr_en) begin
            unique case (reg_sel)
                tsp_pkg::REG_SPLIT_POINT: begin
                    r_cfg.split_point <= pwdata[tsp_pkg::FAST_W-1:0];
                end
                tsp_pkg::REG_IDLE_LIMIT: begin
                    r_cfg.idle_limit <= pwdata[tsp_pkg::IDLE_W-1:0];
                end
                tsp_pkg::REG_DYNAMIC: begin
                    r_cfg.dynamic_en <= pwdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Read-back mux.
    always_comb begin
        prdata = '0;
        unique case (reg_sel)
            tsp_pkg::REG_SPLIT_POINT: begin
                prdata[tsp_pkg::FAST_W-1:0] = r_cfg.split_point;
            end
            tsp_pkg::REG_IDLE_LIMIT: begin
                prdata[tsp_pkg::IDLE_W-1:0] = r_cfg.idle_limit;
            end
            tsp_pkg::REG_DYNAMIC: begin
                prdata[0] = r_cfg.dynamic_en;
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/tsp_ctrl.sv =====
module tsp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  tsp_pkg::t_dp_sts  i_sts,
    output tsp_pkg::t_dp_cmd  o_cmd
);

    tsp_pkg::t_state r_state;
    tsp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state: take a beat, update the task entry, then fold and publish.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tsp_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = tsp_pkg::ST_RMW;
                end
            end
            tsp_pkg::ST_RMW: begin
                n_state = tsp_pkg::ST_FOLD;
            end
            tsp_pkg::ST_FOLD: begin
                if (i_sts.out_free) begin
                    n_state = tsp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tsp_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs. Ready stays low while reset is held.
    always_comb begin
        o_s_tready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            tsp_pkg::ST_IDLE: begin
                o_s_tready = i_rst_n;
                o_cmd.load = i_s_tvalid && i_rst_n;
            end
            tsp_pkg::ST_RMW: begin
                o_cmd.exec = 1'b1;
            end
            tsp_pkg::ST_FOLD: begin
                o_cmd.commit = i_sts.out_free;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/core/tsp_dp.sv =====
module tsp_dp #(
    parameter int TASK_SLOTS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tsp_pkg::t_cfg                  i_cfg,
    input  tsp_pkg::t_dp_cmd               i_cmd,
    output tsp_pkg::t_dp_sts               o_sts,
    input  logic [tsp_pkg::S_DATA_W-1:0]   i_s_tdata,
    input  logic                           i_s_tlast,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [tsp_pkg::M_DATA_W-1:0]   o_m_tdata,
    output logic                           o_m_tlast
);

    // Only slots that a task index can reach need storage.
    localparam int DEPTH = (TASK_SLOTS < tsp_pkg::INDEX_SPAN) ? TASK_SLOTS
                                                              : tsp_pkg::INDEX_SPAN;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EW    = tsp_pkg::TIER_W + tsp_pkg::IDLE_W;
    localparam int IW    = tsp_pkg::TASK_INDEX_W;

    // Captured report.
    logic [IW-1:0]                   r_idx;
    logic [tsp_pkg::EPOCH_IO_W-1:0]  r_io;
    logic                            r_last;
    logic                            r_ent_vld;

    // Step results held for the fold cycle.
    logic                            r_res_tier;
    logic [tsp_pkg::CHANGE_W-1:0]    r_res_change;
    logic [tsp_pkg::IDLE_W-1:0]      r_res_idle;
    logic [tsp_pkg::SUM_W-1:0]       r_esum;

    // Running state.
    logic [DEPTH-1:0]                r_valid;
    logic [tsp_pkg::FAST_W-1:0]      r_fast;
    logic [tsp_pkg::SUM_W-1:0]       r_accum;
    logic [tsp_pkg::SUM_W-1:0]       r_agg;
    logic [tsp_pkg::EPOCH_NUM_W-1:0] r_epoch;

    // Output register.
    logic                            r_out_valid;
    logic [tsp_pkg::M_DATA_W-1:0]    r_out_data;
    logic                            r_out_last;

    logic [IW-1:0]                   in_idx;
    logic [AW-1:0]                   rd_addr;
    logic [AW-1:0]                   addr;
    logic [EW-1:0]                   ram_rdata;
    logic [EW-1:0]                   entry;
    logic                            in_range;
    logic                            apply;
    logic                            tier_old;
    logic [tsp_pkg::IDLE_W-1:0]      idle_old;
    logic                            promote;
    logic                            tier_mid;
    logic [tsp_pkg::FAST_W-1:0]      fast_mid;
    logic [tsp_pkg::IDLE_W-1:0]      idle_new;
    logic                            demote;
    logic                            tier_new;
    logic [tsp_pkg::FAST_W-1:0]      fast_new;
    logic [tsp_pkg::SUM_W:0]         esum_raw;
    logic [tsp_pkg::SUM_W-1:0]       esum;
    logic [tsp_pkg::SUM_W:0]         agg_raw;
    logic [tsp_pkg::SUM_W-1:0]       agg_new;
    logic [tsp_pkg::EPOCH_NUM_W-1:0] epoch_new;
    logic [tsp_pkg::M_DATA_W-1:0]    out_pack;

    assign in_idx  = i_s_tdata[IW-1:0];
    assign rd_addr = in_idx[AW-1:0];
    assign addr    = r_idx[AW-1:0];

    // Task entry store: tier bit over the idle counter.
    tsp_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.exec && apply),
        .i_waddr (addr),
        .i_wdata ({tier_new, idle_new}),
        .i_re    (i_cmd.load),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // Capture the report and the entry's valid bit.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx     <= in_idx;
            r_io      <= i_s_tdata[IW +: tsp_pkg::EPOCH_IO_W];
            r_last    <= i_s_tlast;
            r_ent_vld <= r_valid[rd_addr];
        end
    end

    // Placement decision on the fetched entry.
    always_comb begin
        entry    = r_ent_vld ? ram_rdata : '0;
        tier_old = entry[EW-1];
        idle_old = entry[tsp_pkg::IDLE_W-1:0];
        in_range = ({1'b0, r_idx} < (IW + 1)'(DEPTH));
        apply    = in_range && i_cfg.dynamic_en;

        promote  = !tier_old && (r_fast < i_cfg.split_point);
        tier_mid = tier_old || promote;
        fast_mid = r_fast + tsp_pkg::FAST_W'(promote);

        if (r_io != '0) begin
            idle_new = '0;
        end else if (idle_old < tsp_pkg::IDLE_MAX) begin
            idle_new = idle_old + 1'b1;
        end else begin
            idle_new = idle_old;
        end

        demote   = tier_mid && (idle_new > i_cfg.idle_limit);
        tier_new = tier_mid && !demote;
        if (demote && fast_mid != '0) begin
            fast_new = fast_mid - 1'b1;
        end else begin
            fast_new = fast_mid;
        end

        esum_raw = {1'b0, r_accum} + (tsp_pkg::SUM_W + 1)'(r_io);
        esum     = esum_raw[tsp_pkg::SUM_W] ? '1 : esum_raw[tsp_pkg::SUM_W-1:0];
    end

    // Fold the epoch total into the aggregate on the last report.
    always_comb begin
        agg_raw = {1'b0, r_agg} + {1'b0, r_esum};
        if (r_last) begin
            agg_new = agg_raw[tsp_pkg::SUM_W] ? '1 : agg_raw[tsp_pkg::SUM_W-1:0];
        end else begin
            agg_new = r_agg;
        end
        epoch_new = r_epoch + tsp_pkg::EPOCH_NUM_W'(r_last);
        out_pack  = '0;
        out_pack[tsp_pkg::M_DATA_BITS-1:0] = {epoch_new, agg_new, r_esum, r_res_idle,
                                              r_fast, r_res_change, r_res_tier, r_idx};
    end

    // Step results; tier and idle read zero for an unknown slot.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_esum <= esum;
            if (!in_range) begin
                r_res_tier   <= 1'b0;
                r_res_idle   <= '0;
                r_res_change <= tsp_pkg::CHG_NONE;
            end else if (!i_cfg.dynamic_en) begin
                r_res_tier   <= tier_old;
                r_res_idle   <= idle_old;
                r_res_change <= tsp_pkg::CHG_NONE;
            end else begin
                r_res_tier   <= tier_new;
                r_res_idle   <= idle_new;
                r_res_change <= (promote ? tsp_pkg::CHG_PROMOTE : tsp_pkg::CHG_NONE)
                              | (demote  ? tsp_pkg::CHG_DEMOTE  : tsp_pkg::CHG_NONE);
            end
        end
    end

    // Control-side state: valid bits, fast count, sums, epoch number.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_fast  <= '0;
            r_accum <= '0;
            r_agg   <= '0;
            r_epoch <= '0;
        end else begin
            if (i_cmd.exec) begin
                r_accum <= r_last ? '0 : esum;
                if (apply) begin
                    r_valid[addr] <= 1'b1;
                    r_fast        <= fast_new;
                end
            end
            if (i_cmd.commit) begin
                r_agg   <= agg_new;
                r_epoch <= epoch_new;
            end
        end
    end

    // Output register: holds a result beat until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_data <= out_pack;
            r_out_last <= r_last;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid     = r_out_valid;
    assign o_m_tdata      = r_out_data;
    assign o_m_tlast      = r_out_last;

endmodule

// ===== tb/sv/tiered_storage_placement_epoch_tb.sv =====
`timescale 1ns / 1ps

module tiered_storage_placement_epoch_tb;

    localparam int TASK_SLOTS  = 64;
    localparam int DRAIN_EXTRA = 6;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_s_tvalid = 1'b0;
    logic                            o_s_tready;
    // tdata: task_index [5:0], epoch_io [53:6], zero fill [55:54]
    logic [tsp_pkg::S_DATA_W-1:0]    i_s_tdata = '0;
    logic                            i_s_tlast = 1'b0;
    logic                            o_m_tvalid;
    logic                            i_m_tready = 1'b1;
    // tdata: task_id [5:0], tier [6], change [8:7], fast_users [15:9],
    // idle_epochs [20:16], epoch_sum [84:21], total_io [148:85],
    // epoch_number [180:149], zero fill [183:181]
    logic [tsp_pkg::M_DATA_W-1:0]    o_m_tdata;
    logic                            o_m_tlast;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [tsp_pkg::APB_ADDR_W-1:0]  paddr = '0;
    logic [tsp_pkg::APB_DATA_W-1:0]  pwdata = '0;
    logic [tsp_pkg::APB_DATA_W-1:0]  prdata;
    logic                            pready;

    // Random gaps and stalls are enabled only while this is set.
    bit idling_on = 1'b1;
    int stall_left = 0;

    typedef struct packed {
        logic [tsp_pkg::TASK_INDEX_W-1:0] task_id;
        logic [tsp_pkg::TIER_W-1:0]       tier;
        logic [tsp_pkg::CHANGE_W-1:0]     change;
        logic [tsp_pkg::FAST_W-1:0]       fast_users;
        logic [tsp_pkg::IDLE_W-1:0]       idle_epochs;
        logic [tsp_pkg::SUM_W-1:0]        epoch_sum;
        logic [tsp_pkg::SUM_W-1:0]        total_io;
        logic [tsp_pkg::EPOCH_NUM_W-1:0]  epoch_number;
        logic                             last;
    } t_placement_result;

    // Placement predictor and the queue of results it still waits for.
    class placement_scoreboard;
        bit [tsp_pkg::FAST_W-1:0]      split_point;
        bit [tsp_pkg::IDLE_W-1:0]      idle_limit;
        bit                            dynamic_en;
        bit                            tier_bits [TASK_SLOTS];
        bit [tsp_pkg::IDLE_W-1:0]      idle_counts [TASK_SLOTS];
        bit [tsp_pkg::FAST_W-1:0]      fast_count;
        bit [tsp_pkg::SUM_W-1:0]       epoch_accum;
        bit [tsp_pkg::SUM_W-1:0]       aggregate_io;
        bit [tsp_pkg::EPOCH_NUM_W-1:0] epoch_count;
        t_placement_result             awaited_results [$];
        int                            mismatches;

        function new();
            split_point = tsp_pkg::SPLIT_RESET;
            idle_limit  = tsp_pkg::LIMIT_RESET;
            dynamic_en  = tsp_pkg::DYNAMIC_RESET;
            mismatches  = 0;
        endfunction

        function void set_config(logic [1:0] reg_id, logic [31:0] value);
            case (reg_id)
                tsp_pkg::REG_SPLIT_POINT: split_point = value[tsp_pkg::FAST_W-1:0];
                tsp_pkg::REG_IDLE_LIMIT:  idle_limit  = value[tsp_pkg::IDLE_W-1:0];
                tsp_pkg::REG_DYNAMIC:     dynamic_en  = value[0];
                default: ;
            endcase
        endfunction

        function bit [tsp_pkg::SUM_W-1:0] sat_sum(bit [tsp_pkg::SUM_W-1:0] a,
                                                   bit [tsp_pkg::SUM_W-1:0] b);
            bit [tsp_pkg::SUM_W:0] s;
            s = a + b;
            return s[tsp_pkg::SUM_W] ? '1 : s[tsp_pkg::SUM_W-1:0];
        endfunction

        // Apply one accepted report to the policy state and queue its result.
        function void note_report(bit [tsp_pkg::TASK_INDEX_W-1:0] idx,
                                  bit [tsp_pkg::EPOCH_IO_W-1:0] io, bit last);
            t_placement_result r;
            r = '0;
            r.task_id = idx;
            r.last    = last;
            if (int'(idx) < TASK_SLOTS) begin
                r.tier        = tier_bits[idx];
                r.idle_epochs = idle_counts[idx];
                if (dynamic_en) begin
                    if (r.tier == 1'b0 && fast_count < split_point) begin
                        fast_count = fast_count + 1'b1;
                        r.tier     = 1'b1;
                        r.change   = r.change | tsp_pkg::CHG_PROMOTE;
                    end
                    if (io == '0) begin
                        if (r.idle_epochs != tsp_pkg::IDLE_MAX)
                            r.idle_epochs = r.idle_epochs + 1'b1;
                    end else begin
                        r.idle_epochs = '0;
                    end
                    if (r.idle_epochs > idle_limit && r.tier == 1'b1) begin
                        r.tier = 1'b0;
                        if (fast_count != '0)
                            fast_count = fast_count - 1'b1;
                        r.change = r.change | tsp_pkg::CHG_DEMOTE;
                    end
                    tier_bits[idx]   = r.tier;
                    idle_counts[idx] = r.idle_epochs;
                end
            end
            // Epoch statistics count in every mode.
            epoch_accum = sat_sum(epoch_accum, io);
            r.epoch_sum = epoch_accum;
            if (last) begin
                aggregate_io = sat_sum(aggregate_io, epoch_accum);
                epoch_accum  = '0;
                epoch_count  = epoch_count + 1'b1;
            end
            r.fast_users   = fast_count;
            r.total_io     = aggregate_io;
            r.epoch_number = epoch_count;
            awaited_results.push_back(r);
        endfunction

        function void check_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                mismatches++;
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            end
        endfunction

        // Compare one result beat with the oldest queued result.
        function void check_result(logic [tsp_pkg::M_DATA_W-1:0] data, logic last);
            t_placement_result want;
            if (awaited_results.size() == 0) begin
                mismatches++;
                $error("result beat with no report pending");
                return;
            end
            want = awaited_results.pop_front();
            check_field("task_id", want.task_id, data[5:0]);
            check_field("tier", want.tier, data[6]);
            check_field("change", want.change, data[8:7]);
            check_field("fast_users", want.fast_users, data[15:9]);
            check_field("idle_epochs", want.idle_epochs, data[20:16]);
            check_field("epoch_sum", want.epoch_sum, data[84:21]);
            check_field("total_io", want.total_io, data[148:85]);
            check_field("epoch_number", want.epoch_number, data[180:149]);
            check_field("result_last", want.last, last);
        endfunction

        function int pending_count();
            return awaited_results.size();
        endfunction
    endclass

    placement_scoreboard sb = new();

    tiered_storage_placement_epoch #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Receiver stalls in bursts of random length.
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 18);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Every result beat is checked at the edge that accepts it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_result(o_m_tdata, o_m_tlast);
    end

    // Offer one report beat, sometimes after a random gap, and wait for acceptance.
    // The valid stays high afterwards so back-to-back beats need no toggle.
    task automatic send_report(input logic [tsp_pkg::TASK_INDEX_W-1:0] idx,
                               input logic [tsp_pkg::EPOCH_IO_W-1:0] io,
                               input logic last);
        int gap;
        @(negedge i_clk);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(tsp_pkg::S_DATA_W - tsp_pkg::S_DATA_BITS){1'b0}}, io, idx};
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_report(idx, io, last);
    endtask

    task automatic end_reports();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        i_s_tlast  <= 1'b0;
    endtask

    // Wait until every queued result has arrived, plus some slack.
    task automatic wait_drained();
        @(posedge i_clk);
        while (sb.pending_count() != 0) @(posedge i_clk);
        repeat (DRAIN_EXTRA) @(posedge i_clk);
    endtask

    // Write one register, then read it back.
    task automatic write_reg(input logic [1:0] reg_id, input logic [31:0] value);
        logic [31:0] mask;
        mask = (reg_id == tsp_pkg::REG_SPLIT_POINT) ? 32'h7f :
               (reg_id == tsp_pkg::REG_IDLE_LIMIT)  ? 32'h1f : 32'h1;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_id, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_config(reg_id, value);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.check_field("prdata", value & mask, prdata);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Stop reports, let the pipeline empty, then load a new policy.
    task automatic set_policy(input int split, input int limit, input int dyn);
        end_reports();
        wait_drained();
        write_reg(tsp_pkg::REG_SPLIT_POINT, split);
        write_reg(tsp_pkg::REG_IDLE_LIMIT, limit);
        write_reg(tsp_pkg::REG_DYNAMIC, dyn);
    endtask

    // Random reports: zero_pct sets how often a task did no I/O, pool narrows
    // the slots so that idle runs and repeated promotions build up.
    task automatic random_reports(input int count, input int zero_pct, input int pool);
        logic [tsp_pkg::TASK_INDEX_W-1:0] idx;
        logic [tsp_pkg::EPOCH_IO_W-1:0]   io;
        logic [63:0]                      rnd;
        int                               pick;
        repeat (count) begin
            idx  = tsp_pkg::TASK_INDEX_W'($urandom_range(0, pool - 1));
            pick = $urandom_range(0, 99);
            rnd  = {$urandom, $urandom};
            if (pick < zero_pct)
                io = '0;
            else if (pick % 8 == 0)
                io = '1;
            else if (pick % 8 == 1)
                io = tsp_pkg::EPOCH_IO_W'($urandom_range(1, 15));
            else
                io = rnd[tsp_pkg::EPOCH_IO_W-1:0];
            send_report(idx, io, $urandom_range(0, 15) == 0);
        end
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset policy: split point zero holds every task on the slow tier.
        send_report(6'd0, 48'd0, 1'b0);
        send_report(6'd63, '1, 1'b1);

        // Zero idle limit: an idle slow task is promoted and demoted at once.
        set_policy(64, 0, 1);
        send_report(6'd5, 48'd0, 1'b0);
        send_report(6'd6, 48'd1, 1'b0);
        send_report(6'd6, 48'd0, 1'b0);
        send_report(6'd7, '1, 1'b0);
        send_report(6'd8, 48'd12345, 1'b1);

        // Highest idle limit: fast tasks never leave.
        set_policy(64, 31, 1);
        send_report(6'd7, 48'd0, 1'b0);
        send_report(6'd7, 48'd0, 1'b0);

        // Split point lowered below the fast count: only new promotions stop.
        set_policy(1, 31, 1);
        send_report(6'd9, 48'd3, 1'b0);
        send_report(6'd7, 48'd5, 1'b0);

        // Statistics only: placement and idle counters stay frozen.
        set_policy(1, 2, 0);
        send_report(6'd7, 48'd0, 1'b0);
        send_report(6'd9, 48'd0, 1'b1);

        // Demote both fast tasks, then promote and demote a fresh one.
        set_policy(1, 0, 1);
        send_report(6'd7, 48'd0, 1'b0);
        send_report(6'd8, 48'd0, 1'b0);
        send_report(6'd10, 48'd0, 1'b0);
        send_report(6'd63, '1, 1'b1);

        // Random epochs under a range of policies.
        set_policy(64, 16, 1);
        random_reports(150, 30, 64);
        set_policy(3, 4, 1);
        random_reports(120, 40, 64);
        set_policy(20, 0, 1);
        random_reports(100, 50, 8);
        set_policy(127, 31, 1);
        random_reports(80, 100, 2);
        set_policy(64, 30, 1);
        random_reports(80, 50, 4);
        set_policy(10, 5, 0);
        random_reports(100, 40, 64);
        set_policy(0, 2, 1);
        random_reports(70, 40, 64);

        // Closing stretch at full rate.
        idling_on = 1'b0;
        set_policy(32, 8, 1);
        random_reports(60, 40, 64);
        end_reports();
        wait_drained();

        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
